### rtl/afs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types, constants and rate tables for the ADTS frame sync block.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  localparam int HDR_BITS  = 56;
  localparam int FLEN_LSB  = 13;
  localparam int CHCFG_LSB = 30;
  localparam int IDX_LSB   = 34;
  localparam int PABS_BIT  = 40;

  localparam logic [12:0] HDR_LEN_NOCRC = 13'd7;
  localparam logic [12:0] HDR_LEN_CRC   = 13'd9;
  localparam logic [12:0] SYNC_BYTES    = 13'd2;
  localparam logic [7:0]  BYTE_FF       = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;

  typedef struct packed {
    logic [7:0]  es_byte;
    logic        unit_start;
    logic        stamp_valid;
    logic [62:0] stamp_value;
  } afs_in_t;

  typedef struct packed {
    logic [12:0] frame_length;
    logic [2:0]  channel_config;
    logic [3:0]  rate_index;
    logic [16:0] sample_rate_hz;
    logic [13:0] frame_ticks;
    logic [62:0] frame_stamp;
    logic        has_crc;
    logic [15:0] frame_offset;
  } afs_out_t;

  function automatic logic [16:0] rate_hz(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // Duration of 1024 samples in 90 kHz ticks, rounded down.
  function automatic logic [13:0] rate_ticks(input logic [3:0] idx);
    logic [13:0] t;
    case (idx)
      4'd0:    t = 14'd960;
      4'd1:    t = 14'd1044;
      4'd2:    t = 14'd1440;
      4'd3:    t = 14'd1920;
      4'd4:    t = 14'd2089;
      4'd5:    t = 14'd2880;
      4'd6:    t = 14'd3840;
      4'd7:    t = 14'd4179;
      4'd8:    t = 14'd5760;
      4'd9:    t = 14'd7680;
      4'd10:   t = 14'd8359;
      4'd11:   t = 14'd11520;
      4'd12:   t = 14'd12538;
      default: t = 14'd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/afs_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_in_stage
// Input register that holds one stream byte until the parser consumes it.
// ----------------------------------------------------------------------------
module afs_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  afs_pkg::afs_in_t in_data,
  input  logic             adv,
  output logic             item_vld,
  output afs_pkg::afs_in_t item
);
  import afs_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  afs_in_t item_r;

  assign in_stall = vld_r && !adv;
  assign vld_nxt  = in_stall ? vld_r : in_valid;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule

### rtl/afs_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_parser
// Sync search, header capture, frame byte count and timestamp update.
// ----------------------------------------------------------------------------
module afs_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc_en,
  input  afs_pkg::afs_in_t  item,
  output logic              res_vld,
  output afs_pkg::afs_out_t res
);
  import afs_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  logic                   started_r, started_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   prev_ff_r, prev_ff_nxt;
  logic [HDR_BITS-1:0]    hdr_r, hdr_nxt;
  logic [12:0]            bif_r, bif_nxt;
  logic [13:0]            dur_r, dur_nxt;
  logic [62:0]            stamp_r, stamp_nxt;
  logic [OFFSET_BITS-1:0] ucount_r, ucount_nxt;
  logic [OFFSET_BITS-1:0] sync_off_r, sync_off_nxt;

  logic [OFFSET_BITS-1:0] here;
  logic [12:0]            flen;
  logic [12:0]            hlen;
  logic [3:0]             idx;
  logic [16:0]            rate;
  logic                   body_chk;

  always_comb begin
    started_nxt  = started_r;
    phase_nxt    = phase_r;
    prev_ff_nxt  = prev_ff_r;
    hdr_nxt      = hdr_r;
    bif_nxt      = bif_r;
    dur_nxt      = dur_r;
    stamp_nxt    = stamp_r;
    ucount_nxt   = ucount_r;
    sync_off_nxt = sync_off_r;
    res_vld      = 1'b0;
    res          = '0;
    here         = ucount_r;
    flen         = hdr_r[FLEN_LSB +: 13];
    hlen         = HDR_LEN_CRC;
    idx          = hdr_r[IDX_LSB +: 4];
    rate         = '0;
    body_chk     = 1'b0;

    if (proc_en) begin
      if (item.unit_start) begin
        started_nxt = 1'b1;
        phase_nxt   = PH_SEARCH;
        prev_ff_nxt = 1'b0;
        hdr_nxt     = '0;
        bif_nxt     = '0;
        ucount_nxt  = '0;
        if (item.stamp_valid) begin
          stamp_nxt = item.stamp_value;
        end
      end

      if (started_nxt) begin
        here = ucount_nxt;
        if (ucount_nxt != OFFSET_MAX) begin
          ucount_nxt = ucount_nxt + 1'b1;
        end

        case (phase_nxt)
          PH_HEADER, PH_BODY: begin
            bif_nxt  = bif_nxt + 13'd1;
            body_chk = 1'b1;
            if (phase_nxt == PH_HEADER) begin
              hdr_nxt = {hdr_nxt[HDR_BITS-9:0], item.es_byte};
              flen    = hdr_nxt[FLEN_LSB +: 13];
              hlen    = hdr_nxt[PABS_BIT] ? HDR_LEN_NOCRC : HDR_LEN_CRC;
              if (bif_nxt < HDR_LEN_NOCRC) begin
                body_chk = 1'b0;
              end else if (flen < hlen) begin
                // A length shorter than the header drops it and resumes the search.
                phase_nxt   = PH_SEARCH;
                prev_ff_nxt = 1'b0;
                bif_nxt     = '0;
                body_chk    = 1'b0;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
            flen = hdr_nxt[FLEN_LSB +: 13];
            idx  = hdr_nxt[IDX_LSB +: 4];
            if (body_chk && (bif_nxt >= flen)) begin
              rate = rate_hz(idx);
              if (rate != 17'd0) begin
                dur_nxt = rate_ticks(idx);
              end
              res.frame_length   = flen;
              res.channel_config = hdr_nxt[CHCFG_LSB +: 3];
              res.rate_index     = idx;
              res.sample_rate_hz = rate;
              res.frame_ticks    = dur_nxt;
              res.frame_stamp    = stamp_nxt;
              res.has_crc        = !hdr_nxt[PABS_BIT];
              res.frame_offset   = 16'(sync_off_r);
              res_vld            = 1'b1;
              stamp_nxt          = stamp_nxt + 63'(dur_nxt);
              phase_nxt          = PH_SEARCH;
              prev_ff_nxt        = 1'b0;
              bif_nxt            = '0;
            end
          end
          default: begin
            phase_nxt = PH_SEARCH;
            if (prev_ff_nxt && (item.es_byte[7:4] == SYNC_NIBBLE)) begin
              hdr_nxt     = {{(HDR_BITS-16){1'b0}}, BYTE_FF, item.es_byte};
              bif_nxt     = SYNC_BYTES;
              phase_nxt   = PH_HEADER;
              prev_ff_nxt = 1'b0;
            end else begin
              prev_ff_nxt = (item.es_byte == BYTE_FF);
              if (prev_ff_nxt) begin
                sync_off_nxt = here;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      phase_r    <= PH_SEARCH;
      prev_ff_r  <= 1'b0;
      hdr_r      <= '0;
      bif_r      <= '0;
      dur_r      <= '0;
      stamp_r    <= '0;
      ucount_r   <= '0;
      sync_off_r <= '0;
    end else begin
      started_r  <= started_nxt;
      phase_r    <= phase_nxt;
      prev_ff_r  <= prev_ff_nxt;
      hdr_r      <= hdr_nxt;
      bif_r      <= bif_nxt;
      dur_r      <= dur_nxt;
      stamp_r    <= stamp_nxt;
      ucount_r   <= ucount_nxt;
      sync_off_r <= sync_off_nxt;
    end
  end

endmodule

### rtl/afs_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_out_stage
// Result register that holds a frame descriptor until it is taken.
// ----------------------------------------------------------------------------
module afs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  afs_pkg::afs_out_t res,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_stall,
  output afs_pkg::afs_out_t out_data
);
  import afs_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  afs_out_t data_r;

  assign adv       = !vld_r || !out_stall;
  assign vld_nxt   = adv ? res_vld : vld_r;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      data_r <= res;
    end
  end

endmodule

### rtl/adts_frame_sync_core.sv
`timescale 1ns / 1ps
// Path: a frame's last byte passes from the input register through the parser into the result register.
// Throughput: one stream byte per cycle, set by the single-pass parser update between
// the input register and the result register; a stalled result holds the input register.
// Reset: synchronous active-low rst_n clears the parser state and both valid flags at once.
// ----------------------------------------------------------------------------
// adts_frame_sync_core
// ADTS frame header parser and framer producing one descriptor per frame.
// ----------------------------------------------------------------------------
module adts_frame_sync_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  afs_pkg::afs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output afs_pkg::afs_out_t out_data
);
  import afs_pkg::*;

  logic     adv;
  logic     item_vld;
  afs_in_t  item;
  logic     res_vld;
  afs_out_t res;

  afs_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  afs_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc_en (item_vld && adv),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  afs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/afs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks on the frame descriptor channel of the frame sync core.
// ----------------------------------------------------------------------------
module afs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input afs_pkg::afs_out_t out_data
);
  import afs_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result transfer dropped.");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Stalled result changed.");

  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_length >= HDR_LEN_NOCRC) &&
                  (!out_data.has_crc || (out_data.frame_length >= HDR_LEN_CRC)))
    else $error("Frame shorter than its header.");

  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.sample_rate_hz == 17'd0) ==
                   (out_data.rate_index > 4'd12)))
    else $error("Sample rate does not match its index.");

endmodule

bind adts_frame_sync_core afs_checker u_afs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
